/* src/wbs_pkg.sv */
package wbs_pkg;

  localparam int unsigned MAX_WINDOW_CELLS_DEF = 4096;
  localparam int SAMPLE_W = 32;
  localparam int STAT_W   = 48;
  localparam int COUNT_W  = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic signed [SAMPLE_W-1:0] NODATA_RST = -32'sd589824000;
  localparam logic [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};

  typedef enum logic [2:0] {
    MODE_MEAN = 3'd0,
    MODE_VAR  = 3'd1,
    MODE_STD  = 3'd2,
    MODE_MIN  = 3'd3,
    MODE_MAX  = 3'd4,
    MODE_SUM  = 3'd5
  } stat_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAT_MODE = 1'b0,
    CFG_NODATA    = 1'b1
  } cfg_idx_e;

endpackage

/* src/wbs_if.sv */
interface wbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wbs_pkg::SAMPLE_W-1:0] sample;
  logic                                 last_in_window;
  modport source (output valid, sample, last_in_window, input ready);
  modport sink (input valid, sample, last_in_window, output ready);
endinterface

interface wbs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wbs_pkg::STAT_W-1:0] stat_value;
  logic [wbs_pkg::COUNT_W-1:0]       valid_count;
  logic                               overflowed;
  modport source (output valid, stat_value, valid_count, overflowed, input ready);
  modport sink (input valid, stat_value, valid_count, overflowed, output ready);
endinterface

interface wbs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wbs_pkg::CFG_IDX_W-1:0]   index;
  logic [wbs_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/windowed_block_statistics_core.sv */
// Window statistics over signed Q15.16 samples. Samples arrive one beat per cycle while the
// input is ready; a sample equal to the nodata register is skipped, valid ones are stored (up
// to MAX_WINDOW_CELLS, further ones dropped and flagged), counted, summed and tracked for
// min/max. The beat with last_in_window closes the window: sum, min and max are taken in
// S_START and registered for output in S_FIN; mean is computed in the shared bit-serial
// divider; variance adds a pass over the sample memory (one read port) and a second divider
// run; std adds a bit-serial square root. The input is not ready while the window result is
// computed. One result beat per window waits in an output register, so the next window may
// load while it is pending.
module windowed_block_statistics_core #(
  parameter int unsigned MAX_WINDOW_CELLS = wbs_pkg::MAX_WINDOW_CELLS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  wbs_in_if.sink    in_i,
  wbs_out_if.source out_o,
  wbs_cfg_if.sink   cfg_i
);

  localparam int AW  = (MAX_WINDOW_CELLS > 1) ? $clog2(MAX_WINDOW_CELLS) : 1;
  localparam int CW  = $clog2(MAX_WINDOW_CELLS + 1);
  localparam int SW  = 32 + AW;
  localparam int SQW = 64 + AW;
  localparam int DSW = CW + 1;
  localparam int ITW = $clog2(SQW + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_MDIV  = 7'b0000100,
    S_PASS  = 7'b0001000,
    S_VDIV  = 7'b0010000,
    S_ROOT  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  wbs_pkg::stat_mode_e mode_q;
  logic signed [31:0] nodata_q;
  logic [CW-1:0] cnt_q;
  logic signed [SW-1:0] sum_q;
  logic signed [31:0] ext_q;
  logic drop_q;

  logic [SQW-1:0] dvd_q, quo_q;
  logic [DSW-1:0] dsr_q, rem_q;
  logic [ITW-1:0] it_q;
  logic signed [32:0] mean_q;
  logic [CW-1:0] rd_idx_q;
  logic rv_q, adv_q, sqv_q;
  logic [31:0] ad_q;
  logic [63:0] sq_q;
  logic [SQW-1:0] acc_q;
  logic [63:0] sx_q, sres_q, sbit_q;
  logic signed [47:0] res_q;
  logic ov_q, out_ovf_q;
  logic signed [47:0] out_stat_q;
  logic [12:0] out_cnt_q;

  // input side
  logic in_acc, is_data, room, keep, take_ext;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid && in_i.ready;
  assign is_data = (in_i.sample != nodata_q);
  assign room = (cnt_q < CW'(MAX_WINDOW_CELLS));
  assign keep = in_acc && is_data && room;
  assign take_ext = (cnt_q == '0) ||
                    ((mode_q == wbs_pkg::MODE_MAX) ? (in_i.sample > ext_q)
                                                   : (in_i.sample < ext_q));

  // divider step
  logic [DSW:0] rem_sh, rem_sub;
  logic ge, div_done;
  logic [SQW-1:0] q_fin;
  assign rem_sh  = {rem_q, dvd_q[SQW-1]};
  assign ge      = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  assign div_done = (it_q == ITW'(SQW - 1));
  assign q_fin = {quo_q[SQW-2:0], ge};

  // mean from quotient
  logic [32:0] qm;
  logic signed [32:0] mean_nx;
  assign qm = {1'b0, q_fin[31:0]};
  assign mean_nx = sum_q[SW-1] ? -$signed(qm) : $signed(qm);

  // variance from quotient
  logic [63:0] vsat;
  logic [48:0] vq;
  assign vsat = (|q_fin[SQW-1:64]) ? '1 : q_fin[63:0];
  assign vq = {1'b0, vsat[63:16]} + 49'(vsat[15]);

  // sum magnitude and mean dividend
  logic [SW-1:0] sum_abs;
  logic [SW+1:0] mdvd;
  assign sum_abs = sum_q[SW-1] ? (SW'(0) - sum_q) : sum_q;
  assign mdvd = {1'b0, sum_abs, 1'b0} + (SW+2)'(cnt_q);

  // widening helpers
  logic [SW+47:0] sum_ext;
  logic [CW+12:0] cnt_ext;
  assign sum_ext = {{48{sum_q[SW-1]}}, sum_q};
  assign cnt_ext = {13'b0, cnt_q};

  // memory
  logic [31:0] ram_rdata;
  logic rd_issue;
  assign rd_issue = (state_q == S_PASS) && (rd_idx_q < cnt_q);

  wbs_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW_CELLS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (keep),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(in_i.sample),
    .re_i   (rd_issue),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  logic signed [33:0] diff;
  logic [33:0] diff_abs;
  assign diff = $signed({{2{ram_rdata[31]}}, ram_rdata}) - $signed({mean_q[32], mean_q});
  assign diff_abs = diff[33] ? (34'd0 - diff) : diff;

  logic pass_done;
  assign pass_done = (rd_idx_q == cnt_q) && !rv_q && !adv_q && !sqv_q;

  logic [63:0] trial;
  assign trial = sres_q + sbit_q;

  logic out_free;
  assign out_free = !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && in_i.last_in_window) state_d = S_START;
      S_START: begin
        state_d = S_FIN;
        if ((mode_q == wbs_pkg::MODE_MEAN && cnt_q != '0) ||
            ((mode_q == wbs_pkg::MODE_VAR || mode_q == wbs_pkg::MODE_STD) &&
             cnt_q >= CW'(2))) begin
          state_d = S_MDIV;
        end
      end
      S_MDIV:  if (div_done) state_d = (mode_q == wbs_pkg::MODE_MEAN) ? S_FIN : S_PASS;
      S_PASS:  if (pass_done) state_d = S_VDIV;
      S_VDIV:  if (div_done) state_d = (mode_q == wbs_pkg::MODE_STD) ? S_ROOT : S_FIN;
      S_ROOT:  if (sbit_q == '0) state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= wbs_pkg::MODE_MEAN;
      nodata_q <= wbs_pkg::NODATA_RST;
      cnt_q    <= '0;
      sum_q    <= '0;
      ext_q    <= '0;
      drop_q   <= 1'b0;
      ov_q     <= 1'b0;
      rv_q     <= 1'b0;
      adv_q    <= 1'b0;
      sqv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (wbs_pkg::cfg_idx_e'(cfg_i.index))
          wbs_pkg::CFG_STAT_MODE: mode_q <= wbs_pkg::stat_mode_e'(cfg_i.data[2:0]);
          wbs_pkg::CFG_NODATA:    nodata_q <= $signed(cfg_i.data);
          default: ;
        endcase
      end
      if (keep) begin
        cnt_q <= cnt_q + CW'(1);
        sum_q <= sum_q + SW'(in_i.sample);
        if (take_ext) ext_q <= in_i.sample;
      end
      if (in_acc && is_data && !room) drop_q <= 1'b1;
      rv_q  <= rd_issue;
      adv_q <= rv_q;
      sqv_q <= adv_q;
      if (state_q == S_FIN && out_free) begin
        ov_q   <= 1'b1;
        cnt_q  <= '0;
        sum_q  <= '0;
        ext_q  <= '0;
        drop_q <= 1'b0;
      end else if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    it_q  <= it_q + ITW'(1);
    dvd_q <= {dvd_q[SQW-2:0], 1'b0};
    quo_q <= q_fin;
    rem_q <= rem_sub[DSW-1:0];
    ad_q  <= diff_abs[31:0];
    sq_q  <= ad_q * ad_q;
    if (sqv_q) acc_q <= acc_q + SQW'(sq_q);
    if (rd_issue) rd_idx_q <= rd_idx_q + CW'(1);
    if (sbit_q != '0) begin
      if (sx_q >= trial) begin
        sx_q   <= sx_q - trial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    case (state_q)
      S_START: begin
        case (mode_q)
          wbs_pkg::MODE_SUM: res_q <= sum_ext[47:0];
          wbs_pkg::MODE_MIN,
          wbs_pkg::MODE_MAX: res_q <= (cnt_q != '0) ? 48'(ext_q) : '0;
          wbs_pkg::MODE_MEAN,
          wbs_pkg::MODE_VAR,
          wbs_pkg::MODE_STD: res_q <= 48'(nodata_q);
          default: res_q <= '0;
        endcase
        dvd_q <= SQW'(mdvd);
        dsr_q <= {cnt_q, 1'b0};
        rem_q <= '0;
        it_q  <= '0;
      end
      S_MDIV: if (div_done) begin
        mean_q   <= mean_nx;
        res_q    <= 48'(mean_nx);
        rd_idx_q <= '0;
        acc_q    <= '0;
      end
      S_PASS: if (pass_done) begin
        dvd_q <= acc_q;
        dsr_q <= DSW'(cnt_q - CW'(1));
        rem_q <= '0;
        it_q  <= '0;
      end
      S_VDIV: if (div_done) begin
        res_q  <= (vq > 49'(wbs_pkg::STAT_MAX)) ? wbs_pkg::STAT_MAX : vq[47:0];
        sx_q   <= vsat;
        sres_q <= '0;
        sbit_q <= 64'd1 << 62;
      end
      S_ROOT: if (sbit_q == '0) res_q <= {16'b0, sres_q[31:0]};
      default: ;
    endcase
    if (state_q == S_FIN && out_free) begin
      out_stat_q <= res_q;
      out_cnt_q  <= cnt_ext[12:0];
      out_ovf_q  <= drop_q;
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = ov_q;
  assign out_o.stat_value  = out_stat_q;
  assign out_o.valid_count = out_cnt_q;
  assign out_o.overflowed  = out_ovf_q;

endmodule

/* src/wbs_ram.sv */
module wbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/wbs_checker.sv */
module wbs_checker #(
  parameter int unsigned MAX_WINDOW_CELLS = wbs_pkg::MAX_WINDOW_CELLS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [47:0] out_stat_i,
  input logic [12:0] out_count_i,
  input logic        out_ovf_i
);

  localparam logic [31:0] MAXC = 32'(MAX_WINDOW_CELLS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_stat_i) &&
    $stable(out_count_i) && $stable(out_ovf_i))
    else $error("result beat changed while stalled");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input ready right after window end");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> {19'b0, out_count_i} <= MAXC)
    else $error("valid_count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ovf_i |-> out_count_i == MAXC[12:0])
    else $error("overflow flagged with room left");

endmodule

bind windowed_block_statistics_core wbs_checker #(
  .MAX_WINDOW_CELLS(MAX_WINDOW_CELLS)
) u_wbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.last_in_window),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_stat_i (out_o.stat_value),
  .out_count_i(out_o.valid_count),
  .out_ovf_i  (out_o.overflowed)
);
